// File: rtl/scope_name_hash_table_unit_macros.svh
// assertion macros for the hash table rtl
`ifndef SCOPE_NAME_HASH_TABLE_UNIT_MACROS_SVH
`define SCOPE_NAME_HASH_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SNHT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("snht assertion failed");

// condition must never be seen outside reset
`define SNHT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("snht forbidden condition seen");

`else

`define SNHT_ASSERT(lbl, prop)
`define SNHT_NEVER(lbl, cond)

`endif

`endif

// File: rtl/snht_pkg.sv
package snht_pkg;

    // table geometry
    localparam int SLOT_COUNT  = 64;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam bit SLOT_POW2   = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);
    // entries allowed before the load limit refuses an insert
    localparam int MAX_ENTRIES = (SLOT_COUNT * 7) / 10;

    // key and hash widths
    localparam int ID_W     = 16;
    localparam int KEY_W    = 2 * ID_W;
    localparam int HASH_W   = 32;
    localparam logic [HASH_W-1:0] MIX_CONST = 32'h9e37_79b9;

    // result field widths
    localparam int IDX_W    = 6;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // hash unit result towards the probe controller
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] slot;
    } t_hash_rsp;

endpackage

// File: rtl/snht_req_if.sv
interface snht_req_if;
    import snht_pkg::*;

    logic            valid;
    logic            ready;
    logic            req_type;
    logic [ID_W-1:0] scope_id;
    logic [ID_W-1:0] name_id;

    modport source (output valid, output req_type, output scope_id, output name_id,
                    input ready);
    modport sink   (input valid, input req_type, input scope_id, input name_id,
                    output ready);
endinterface

// File: rtl/snht_rsp_if.sv
interface snht_rsp_if;
    import snht_pkg::*;

    logic             valid;
    logic             ready;
    t_status          status;
    logic [IDX_W-1:0] entry_index;

    modport source (output valid, output status, output entry_index, input ready);
    modport sink   (input valid, input status, input entry_index, output ready);
endinterface

// File: rtl/snht_ram.sv
module snht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// File: rtl/snht_hash.sv
module snht_hash (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [snht_pkg::ID_W-1:0] i_scope,
    input  logic [snht_pkg::ID_W-1:0] i_name,
    output snht_pkg::t_hash_rsp    o_rsp
);
    import snht_pkg::*;

    logic [HASH_W-1:0] mix;

    // scope ^ (name + const + (scope << 6) + (scope >> 2)); the sum stays below 2^32
    always_comb begin
        mix = (HASH_W'(i_name) + MIX_CONST + (HASH_W'(i_scope) << 6)
               + HASH_W'(i_scope >> 2)) ^ HASH_W'(i_scope);
    end

    if (SLOT_POW2) begin : g_mask
        logic [SLOT_W-1:0] r_slot;
        logic              r_done;

        // home slot is the low bits of the hash
        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_slot <= mix[SLOT_W-1:0];
            end
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
        end

        assign o_rsp.done = r_done;
        assign o_rsp.slot = r_slot;
    end else begin : g_recip
        // slot count reciprocal scaled by 2^32
        localparam logic [HASH_W-1:0] RECIP =
            HASH_W'((64'd1 << HASH_W) / 64'(SLOT_COUNT));
        localparam logic [SLOT_W:0]   SLOT_N = (SLOT_W + 1)'(SLOT_COUNT);

        logic [HASH_W-1:0]   r_hash;
        logic                r_hash_vld;
        logic [SLOT_W:0]     r_hash_lo;
        logic [SLOT_W:0]     r_quot_lo;
        logic                r_quot_vld;
        logic [SLOT_W-1:0]   r_rem;
        logic                r_done;
        logic [2*HASH_W-1:0] prod;
        logic [SLOT_W:0]     diff;
        logic [SLOT_W:0]     n_rem;

        // quotient estimate is low by at most one, so the remainder left
        // after it is below twice the slot count and one subtract fixes it
        always_comb begin
            prod  = {{HASH_W{1'b0}}, r_hash} * {{HASH_W{1'b0}}, RECIP};
            diff  = r_hash_lo - (r_quot_lo * SLOT_N);
            n_rem = (diff >= SLOT_N) ? diff - SLOT_N : diff;
        end

        // three stage pipe: hash, quotient estimate, remainder
        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_hash <= mix;
            end
            if (r_hash_vld) begin
                r_hash_lo <= r_hash[SLOT_W:0];
                r_quot_lo <= prod[HASH_W +: SLOT_W + 1];
            end
            if (r_quot_vld) begin
                r_rem <= n_rem[SLOT_W-1:0];
            end
            if (!i_rst_n) begin
                r_hash_vld <= 1'b0;
                r_quot_vld <= 1'b0;
                r_done     <= 1'b0;
            end else begin
                r_hash_vld <= i_start;
                r_quot_vld <= r_hash_vld;
                r_done     <= r_quot_vld;
            end
        end

        assign o_rsp.done = r_done;
        assign o_rsp.slot = r_rem;
    end
endmodule

// File: rtl/scope_name_hash_table_unit.sv
// Hash table of (scope, name) id pairs with linear probing over a slot memory and a
// key memory. After reset the slot memory is cleared in a pass over all SLOT_COUNT
// slots during which no request is taken. A request is then hashed to its home slot
// and probed from there until an empty slot or a slot holding the key is found;
// each probe step is a slot memory read followed by a key memory read. When
// SLOT_COUNT is not a power of two the home slot comes from a reciprocal
// multiplication pipeline rather than the low hash bits. Inserts beyond 70% load are
// refused with the full status; a result waits in an output register while the next
// request is taken.
`include "scope_name_hash_table_unit_macros.svh"

module scope_name_hash_table_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    snht_req_if.sink   i_req,
    snht_rsp_if.source o_rsp
);
    import snht_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_SLOT_CHK,
        S_KEY_CHK,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_ensure, n_ensure;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_tag, n_tag;
    logic [SLOT_W-1:0] r_count, n_count;
    t_status           r_res_status, n_res_status;
    logic [SLOT_W-1:0] r_res_index, n_res_index;
    logic              r_rsp_valid, n_rsp_valid;
    t_status           r_out_status, n_out_status;
    logic [IDX_W-1:0]  r_out_index, n_out_index;

    logic              accept;
    logic              do_insert;
    logic [SLOT_W-1:0] next_slot;
    t_hash_rsp         hash_rsp;

    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr, slot_wdata, slot_raddr, slot_rdata;
    logic              key_we;
    logic [SLOT_W-1:0] key_waddr, key_raddr;
    logic [KEY_W-1:0]  key_rdata;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign next_slot   = (r_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_slot + 1'b1;

    // home slot of the accepted key
    snht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_scope (i_req.scope_id),
        .i_name  (i_req.name_id),
        .o_rsp   (hash_rsp)
    );

    // slot store: zero is empty, otherwise entry index plus one
    snht_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // key store indexed by entry
    snht_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // probe sequencer
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_ensure     = r_ensure;
        n_key        = r_key;
        n_slot       = r_slot;
        n_tag        = r_tag;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        slot_we      = 1'b0;
        slot_waddr   = r_slot;
        slot_wdata   = r_count + 1'b1;
        slot_raddr   = r_slot;
        key_we       = 1'b0;
        key_waddr    = r_count;
        key_raddr    = slot_rdata - 1'b1;
        do_insert    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr_addr;
                slot_wdata = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SLOT_W'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_ensure = i_req.req_type;
                    n_key    = {i_req.scope_id, i_req.name_id};
                    n_state  = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_rsp.done) begin
                    slot_raddr = hash_rsp.slot;
                    n_slot     = hash_rsp.slot;
                    n_state    = S_SLOT_CHK;
                end
            end
            S_SLOT_CHK: begin
                if (slot_rdata == '0) begin
                    // empty slot ends the probe run
                    n_res_index  = '0;
                    n_res_status = ST_NOT_FOUND;
                    if (r_ensure) begin
                        if (r_count >= SLOT_W'(MAX_ENTRIES)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            do_insert    = 1'b1;
                            slot_we      = 1'b1;
                            key_we       = 1'b1;
                            n_count      = r_count + 1'b1;
                            n_res_index  = r_count;
                            n_res_status = ST_INSERTED;
                        end
                    end
                    n_state = S_DONE;
                end else begin
                    n_tag   = slot_rdata;
                    n_state = S_KEY_CHK;
                end
            end
            S_KEY_CHK: begin
                if (key_rdata == r_key) begin
                    n_res_status = ST_FOUND;
                    n_res_index  = r_tag - 1'b1;
                    n_state      = S_DONE;
                end else begin
                    // collision: move on to the next slot with wrap-around
                    slot_raddr = next_slot;
                    n_slot     = next_slot;
                    n_state    = S_SLOT_CHK;
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = IDX_W'(r_res_index);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ensure     <= n_ensure;
        r_key        <= n_key;
        r_slot       <= n_slot;
        r_tag        <= n_tag;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // result register towards the sink
    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_index = r_out_index;

    // an insert bumps the entry count by exactly one
    `SNHT_ASSERT(a_insert_count, (r_state == S_SLOT_CHK && do_insert) |=> (r_count == $past(r_count) + 1'b1))
    // the slot store is only written by the clearing pass or an insert
    `SNHT_NEVER(a_slot_write_src, slot_we && !(r_state == S_CLEAR) && !do_insert)
    // a key check always follows an occupied slot
    `SNHT_ASSERT(a_key_chk_tag, (r_state == S_KEY_CHK) |-> (r_tag != '0))
    // the load limit is never passed
    `SNHT_NEVER(a_load_limit, r_count > SLOT_W'(MAX_ENTRIES))
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import snht_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int LONG_HOLD      = 150;
    localparam int MISSED_KEEP    = 32;

    localparam logic REQ_FIND   = 1'b0;
    localparam logic REQ_ENSURE = 1'b1;

    // scope kept out of random keys so the load limit rows stay predictable
    localparam logic [ID_W-1:0] RESERVED_SCOPE = 16'hA5A5;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] entry_index;
    } t_lookup_result;

    typedef struct packed {
        logic             ensure;
        logic [ID_W-1:0]  scope_id;
        logic [ID_W-1:0]  name_id;
        logic             typed;
        t_status          status;
        logic [IDX_W-1:0] entry_index;
    } t_request_row;

    // directed requests; rows with typed clear are checked against the table model
    localparam int EARLY_ROWS = 21;
    localparam int ROW_COUNT  = 26;
    localparam t_request_row STIMULUS_ROWS [ROW_COUNT] = '{
        // empty table
        '{REQ_FIND,   16'h0000, 16'h0000, 1'b1, ST_NOT_FOUND, 6'd0},
        '{REQ_FIND,   16'hFFFF, 16'hFFFF, 1'b1, ST_NOT_FOUND, 6'd0},
        // first inserts and lookups at the field extremes
        '{REQ_ENSURE, 16'h0000, 16'h0000, 1'b1, ST_INSERTED,  6'd0},
        '{REQ_ENSURE, 16'h0000, 16'h0000, 1'b1, ST_FOUND,     6'd0},
        '{REQ_FIND,   16'h0000, 16'h0000, 1'b1, ST_FOUND,     6'd0},
        '{REQ_ENSURE, 16'hFFFF, 16'hFFFF, 1'b1, ST_INSERTED,  6'd1},
        '{REQ_FIND,   16'hFFFF, 16'hFFFF, 1'b1, ST_FOUND,     6'd1},
        '{REQ_ENSURE, 16'hFFFF, 16'h0000, 1'b1, ST_INSERTED,  6'd2},
        '{REQ_ENSURE, 16'h0000, 16'hFFFF, 1'b1, ST_INSERTED,  6'd3},
        '{REQ_FIND,   16'h0000, 16'hFFFE, 1'b1, ST_NOT_FOUND, 6'd0},
        '{REQ_FIND,   16'hFFFF, 16'h0000, 1'b1, ST_FOUND,     6'd2},
        // same home slot as key (0, 0): probe chain
        '{REQ_ENSURE, 16'h0000, 16'h0040, 1'b1, ST_INSERTED,  6'd4},
        '{REQ_ENSURE, 16'h0000, 16'h0080, 1'b1, ST_INSERTED,  6'd5},
        '{REQ_FIND,   16'h0000, 16'h0080, 1'b1, ST_FOUND,     6'd5},
        '{REQ_FIND,   16'h0000, 16'h00C0, 1'b0, ST_NOT_FOUND, 6'd0},
        '{REQ_FIND,   16'h0000, 16'h0040, 1'b1, ST_FOUND,     6'd4},
        // home in the last slot: probe wraps to slot 0
        '{REQ_ENSURE, 16'h0000, 16'h0006, 1'b1, ST_INSERTED,  6'd6},
        '{REQ_ENSURE, 16'h0000, 16'h0046, 1'b1, ST_INSERTED,  6'd7},
        '{REQ_FIND,   16'h0000, 16'h0046, 1'b1, ST_FOUND,     6'd7},
        '{REQ_ENSURE, 16'h0000, 16'h0086, 1'b1, ST_INSERTED,  6'd8},
        '{REQ_FIND,   16'h0000, 16'h0106, 1'b0, ST_NOT_FOUND, 6'd0},
        // table at its load limit
        '{REQ_ENSURE, 16'hA5A5, 16'h5A5A, 1'b1, ST_FULL,      6'd0},
        '{REQ_ENSURE, 16'h0000, 16'h0000, 1'b1, ST_FOUND,     6'd0},
        '{REQ_FIND,   16'hA5A5, 16'h5A5A, 1'b1, ST_NOT_FOUND, 6'd0},
        '{REQ_ENSURE, 16'hFFFF, 16'hFFFF, 1'b1, ST_FOUND,     6'd1},
        '{REQ_ENSURE, 16'hA5A5, 16'h0000, 1'b1, ST_FULL,      6'd0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    snht_req_if req_ch ();
    snht_rsp_if rsp_ch ();

    scope_name_hash_table_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // table model state
    int               slot_tags   [SLOT_COUNT];
    logic [KEY_W-1:0] entry_keys  [SLOT_COUNT];
    int               stored_entries;

    t_lookup_result   pending_lookups [$];
    t_lookup_result   oldest_lookup;
    logic [KEY_W-1:0] inserted_keys [$];
    logic [KEY_W-1:0] missed_keys [$];

    int mismatch_count;
    int quiet_cycles;
    bit idle_on;
    bit hold_request;

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mix hash of the key pair, taken modulo the slot count
    function automatic int home_slot(input logic [ID_W-1:0] scope, input logic [ID_W-1:0] name);
        logic [63:0] mix;
        mix = {48'd0, scope};
        mix = mix ^ ({48'd0, name} + 64'h9e37_79b9 + (mix << 6) + (mix >> 2));
        return int'(mix % 64'(SLOT_COUNT));
    endfunction

    // linear probe from the home slot; ensure appends a new entry on a miss
    function automatic t_lookup_result table_lookup(input logic ensure,
                                                    input logic [ID_W-1:0] scope,
                                                    input logic [ID_W-1:0] name);
        logic [KEY_W-1:0] key;
        t_lookup_result   res;
        int               slot;
        int               tag;
        bit               hit;
        bit               have_empty;
        key        = {scope, name};
        slot       = home_slot(scope, name);
        hit        = 1'b0;
        have_empty = 1'b0;
        res.status      = ST_NOT_FOUND;
        res.entry_index = '0;
        for (int n = 0; n < SLOT_COUNT; n++) begin
            tag = slot_tags[slot];
            if (tag == 0) begin
                have_empty = 1'b1;
                break;
            end
            if (entry_keys[tag-1] == key) begin
                hit             = 1'b1;
                res.status      = ST_FOUND;
                res.entry_index = IDX_W'(tag - 1);
                break;
            end
            slot = (slot + 1) % SLOT_COUNT;
        end
        if (!hit && ensure) begin
            if ((stored_entries + 1) * 10 > SLOT_COUNT * 7 || !have_empty) begin
                res.status = ST_FULL;
            end else begin
                entry_keys[stored_entries] = key;
                stored_entries++;
                slot_tags[slot] = stored_entries;
                res.status      = ST_INSERTED;
                res.entry_index = IDX_W'(stored_entries - 1);
            end
        end
        return res;
    endfunction

    // new key: random, at the field extremes, or aimed at an occupied home slot
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [ID_W-1:0]  scope;
        logic [ID_W-1:0]  name;
        logic [KEY_W-1:0] other;
        logic [5:0]       low;
        scope = ID_W'($urandom);
        name  = ID_W'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                if ($urandom_range(0, 1) == 1) scope = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0;
                if ($urandom_range(0, 1) == 1) name = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0;
                if (scope == RESERVED_SCOPE) scope = ~scope;
            end
            1, 2: begin
                if (scope == RESERVED_SCOPE) scope = ~scope;
                if (inserted_keys.size() > 0) begin
                    other = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                    low   = 6'(home_slot(other[KEY_W-1:ID_W], other[ID_W-1:0])) ^ scope[5:0];
                    low   = low - 6'h39 - scope[7:2];
                    name[5:0] = low;
                end
            end
            default: begin
                if (scope == RESERVED_SCOPE) scope = ~scope;
            end
        endcase
        return {scope, name};
    endfunction

    // offer one item, wait for acceptance, then record what the table should answer
    task automatic send_request(input logic ensure, input logic [ID_W-1:0] scope,
                                input logic [ID_W-1:0] name, input logic typed,
                                input t_status typed_status,
                                input logic [IDX_W-1:0] typed_index);
        int             gap;
        t_lookup_result predicted;
        t_lookup_result wanted;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.req_type = ensure;
        req_ch.scope_id = scope;
        req_ch.name_id  = name;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = table_lookup(ensure, scope, name);
        wanted.status      = typed_status;
        wanted.entry_index = typed_index;
        pending_lookups.insert(pending_lookups.size(), typed ? wanted : predicted);
        // key pools for later requests
        if (predicted.status == ST_INSERTED) begin
            inserted_keys.insert(inserted_keys.size(), {scope, name});
        end else if (predicted.status != ST_FOUND) begin
            missed_keys.insert(missed_keys.size(), {scope, name});
            if (missed_keys.size() > MISSED_KEEP) void'(missed_keys.pop_front());
        end
    endtask

    task automatic send_row(input int row);
        send_request(STIMULUS_ROWS[row].ensure, STIMULUS_ROWS[row].scope_id,
                     STIMULUS_ROWS[row].name_id, STIMULUS_ROWS[row].typed,
                     STIMULUS_ROWS[row].status, STIMULUS_ROWS[row].entry_index);
    endtask

    // known keys most often, then fresh keys (a few of them inserts) and missed keys
    task automatic send_random_request();
        logic [KEY_W-1:0] key;
        logic             ensure;
        int               r;
        r      = $urandom_range(0, 99);
        ensure = logic'($urandom_range(0, 1));
        if (r < 45 && inserted_keys.size() > 0) begin
            key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        end else if (r < 57 && missed_keys.size() > 0) begin
            key = missed_keys[$urandom_range(0, missed_keys.size() - 1)];
        end else begin
            key    = fresh_key();
            ensure = (r < 65) ? REQ_ENSURE : REQ_FIND;
        end
        send_request(ensure, key[KEY_W-1:ID_W], key[ID_W-1:0], 1'b0, ST_FOUND, '0);
    endtask

    task automatic run_random(input int count, input int hold_at, input int quiet_from);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_request = 1'b1;
            if (i == quiet_from) idle_on = 1'b0;
            send_random_request();
        end
    endtask

    // stop offering items until every outstanding result is back
    task automatic wait_all_results();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_lookups.size() > 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [KEY_W-1:0] key;
        idle_on         = 1'b1;
        hold_request    = 1'b0;
        stored_entries  = 0;
        mismatch_count  = 0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_FIND;
        req_ch.scope_id = '0;
        req_ch.name_id  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < EARLY_ROWS; i++) send_row(i);
        run_random(550, -1, -1);

        // top the table up to its load limit
        while ((stored_entries + 1) * 10 <= SLOT_COUNT * 7) begin
            key = fresh_key();
            send_request(REQ_ENSURE, key[KEY_W-1:ID_W], key[ID_W-1:0], 1'b0, ST_FOUND, '0);
        end
        wait_all_results();

        for (int i = EARLY_ROWS; i < ROW_COUNT; i++) send_row(i);
        run_random(1150, 200, 850);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // result side ready: short stall bursts and one long hold-off
    initial begin
        rsp_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                rsp_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: unexpected result, status %0d index %0d", $time,
                         rsp_ch.status, rsp_ch.entry_index);
                mismatch_count++;
            end else begin
                oldest_lookup = pending_lookups.pop_front();
                if (rsp_ch.status !== oldest_lookup.status ||
                    rsp_ch.entry_index !== oldest_lookup.entry_index) begin
                    $display("%0t: result mismatch, expected status %0d index %0d, got status %0d index %0d",
                             $time, oldest_lookup.status, oldest_lookup.entry_index,
                             rsp_ch.status, rsp_ch.entry_index);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
